@@ design/lfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfpd_pkg: shared definitions for the line-follow PID drive
// Widths, register indexes, sequencer states and the sensor position table.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    localparam int DUTY_BITS = 8;
    localparam logic [7:0] DUTY_MASK =
        (DUTY_BITS >= 8) ? 8'hFF : 8'((1 << DUTY_BITS) - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 3'd4;

    localparam logic [15:0] KP_RESET   = 16'd7680;
    localparam logic [15:0] KI_RESET   = 16'd1280;
    localparam logic [15:0] KD_RESET   = 16'd5120;
    localparam logic [7:0]  BASE_RESET = 8'd70;
    localparam logic [7:0]  MAX_RESET  = 8'd255;

    // Shared divider: dividend magnitude width, two quotient bits per cycle.
    localparam int DIV_BITS  = 34;
    localparam int DIV_STEPS = DIV_BITS / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [15:0] MS_PER_S = 16'd1000;

    // Integral limit of 50 in Q7.16.
    localparam logic signed [25:0] INT_LIMIT = 26'sd3276800;

    // Mean hit position in Q2.8, truncated toward zero, for every hit pattern.
    // The empty pattern is never used: the previous error stands in for it.
    localparam logic signed [10:0] ERR_LUT [32] = '{
        11'sd0,    -11'sd512, -11'sd256, -11'sd384,
        11'sd0,    -11'sd256, -11'sd128, -11'sd256,
        11'sd256,  -11'sd128,  11'sd0,   -11'sd170,
        11'sd128,  -11'sd85,   11'sd0,   -11'sd128,
        11'sd512,   11'sd0,    11'sd128, -11'sd85,
        11'sd256,   11'sd0,    11'sd85,  -11'sd64,
        11'sd384,   11'sd85,   11'sd170,  11'sd0,
        11'sd256,   11'sd64,   11'sd128,  11'sd0
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_EMS,
        S_LOAD_I,
        S_DIV_I,
        S_ACC_I,
        S_DIV_D,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_SUM,
        S_CMD_L,
        S_DRV_L,
        S_CMD_R,
        S_DRV_R,
        S_PUT
    } t_state;

endpackage

@@ design/lfpd_in_if.sv @@
// ----------------------------------------------------------------------------
// lfpd_in_if: input channel of the line-follow PID drive
// One beat carries the enable bit, the sensor hits and the elapsed time.
// ----------------------------------------------------------------------------
interface lfpd_in_if;
    logic        valid;
    logic        ready;
    logic        enabled;
    logic [4:0]  sensor_hits;
    logic [15:0] elapsed_ms;

    modport source (output valid, enabled, sensor_hits, elapsed_ms, input ready);
    modport sink   (input valid, enabled, sensor_hits, elapsed_ms, output ready);
endinterface

@@ design/lfpd_out_if.sv @@
// ----------------------------------------------------------------------------
// lfpd_out_if: result channel of the line-follow PID drive
// One beat carries duty and direction for both motors.
// ----------------------------------------------------------------------------
interface lfpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_duty;
    logic       left_reverse;
    logic [7:0] right_duty;
    logic       right_reverse;

    modport source (output valid, left_duty, left_reverse, right_duty, right_reverse,
                    input ready);
    modport sink   (input valid, left_duty, left_reverse, right_duty, right_reverse,
                    output ready);
endinterface

@@ design/line_follow_pid_drive.sv @@
// ----------------------------------------------------------------------------
// line_follow_pid_drive: PID line follower with differential motor drive
// One control step per input beat, computed on a shared multiplier and a
// shared two-bit-per-cycle divider under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake        Contents
//  i_cfg     in   i_cfg_we only    index 0..4, kp/ki/kd/base/max
//  i_in      in   valid/ready      enabled, sensor_hits, elapsed_ms
//  o_out     out  valid/ready      left/right duty and reverse
//
//  An enabled step runs from acceptance to the result register through two
//  passes of the shared divider (integral over 1000, derivative over elapsed
//  time); a disabled step goes straight to the result register.
//  The input is ready again as soon as the result is loaded.
//  A result waits in the output register while the next beat is accepted;
//  a second result waits in the sequencer until the first is taken.
//  Reset is synchronous and restores the register defaults and zero state.
// ----------------------------------------------------------------------------
module line_follow_pid_drive (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lfpd_in_if.sink                       i_in,
    lfpd_out_if.source                    o_out
);
    import lfpd_pkg::*;

    t_state r_state, n_state;

    logic [15:0] r_kp, r_ki, r_kd;
    logic [7:0]  r_base, r_max;

    logic signed [10:0] r_prev;
    logic signed [22:0] r_int;
    logic signed [10:0] r_err;
    logic [15:0]        r_ms;
    logic signed [20:0] r_deriv;
    logic signed [40:0] r_prod;
    logic signed [47:0] r_acc;
    logic signed [47:0] r_cmd;

    logic [15:0]          r_rem;
    logic [DIV_BITS-1:0]  r_quo;
    logic [15:0]          r_dvsr;
    logic                 r_dneg;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [7:0] r_l_duty, r_r_duty;
    logic       r_l_rev, r_r_rev;

    logic       r_o_valid;
    logic [7:0] r_o_l_duty, r_o_r_duty;
    logic       r_o_l_rev, r_o_r_rev;

    logic signed [23:0] w_ma;
    logic signed [16:0] w_mb;
    logic signed [40:0] w_prod;
    logic [40:0]        w_prod_abs;
    logic signed [47:0] w_prod48;
    logic signed [11:0] w_diff;
    logic signed [25:0] w_inc, w_int_sum;
    logic signed [22:0] w_int_clamped;
    logic signed [20:0] w_q21;
    logic signed [47:0] w_base48;
    logic [47:0]        w_cmd_abs;
    logic [23:0]        w_whole;
    logic [7:0]         w_lim;
    logic [7:0]         w_duty;
    logic               w_rev;
    logic [15+DIV_BITS:0] w_div_next;
    logic               w_accept;
    logic               w_div_last;
    logic               w_slot_free;

    // Two restoring division steps: remainder stays below the divisor.
    function automatic logic [15+DIV_BITS:0] f_div_step(
        input logic [15:0]         rem,
        input logic [DIV_BITS-1:0] q,
        input logic [15:0]         d
    );
        logic [16:0]         t;
        logic [15:0]         r;
        logic [DIV_BITS-1:0] qq;
        r  = rem;
        qq = q;
        for (int k = 0; k < 2; k++) begin
            t  = {r, qq[DIV_BITS-1]};
            qq = {qq[DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t     = t - {1'b0, d};
                qq[0] = 1'b1;
            end
            r = t[15:0];
        end
        return {r, qq};
    endfunction

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_div_last  = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign w_slot_free = !r_o_valid || o_out.ready;

    // Shared multiplier operand selection.
    always_comb begin
        w_diff = $signed({r_err[10], r_err}) - $signed({r_prev[10], r_prev});
        w_ma   = '0;
        w_mb   = '0;
        case (r_state)
            S_MUL_EMS: begin
                w_ma = 24'(r_err);
                w_mb = $signed({1'b0, r_ms});
            end
            S_LOAD_I: begin
                w_ma = 24'(w_diff);
                w_mb = $signed({1'b0, MS_PER_S});
            end
            S_MUL_P: begin
                w_ma = 24'(r_err);
                w_mb = $signed({1'b0, r_kp});
            end
            S_MUL_I: begin
                w_ma = 24'(r_int);
                w_mb = $signed({1'b0, r_ki});
            end
            S_MUL_D: begin
                w_ma = 24'(r_deriv);
                w_mb = $signed({1'b0, r_kd});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    always_comb begin
        w_prod_abs = r_prod[40] ? 41'(-r_prod) : 41'(r_prod);
        w_prod48   = 48'(r_prod);
        w_div_next = f_div_step(r_rem, r_quo, r_dvsr);

        w_inc     = $signed({2'b00, r_quo[23:0]});
        w_int_sum = r_dneg ? (26'(r_int) - w_inc) : (26'(r_int) + w_inc);
        if (w_int_sum > INT_LIMIT) begin
            w_int_clamped = 23'(INT_LIMIT);
        end else if (w_int_sum < -INT_LIMIT) begin
            w_int_clamped = 23'(-INT_LIMIT);
        end else begin
            w_int_clamped = w_int_sum[22:0];
        end

        w_q21 = $signed({1'b0, r_quo[19:0]});

        w_base48  = $signed({16'h0000, r_base, 24'h000000});
        w_cmd_abs = r_cmd[47] ? 48'(-r_cmd) : 48'(r_cmd);
        w_whole   = w_cmd_abs[47:24];
        w_lim     = (w_whole > {16'h0000, r_max}) ? r_max : w_whole[7:0];
        w_duty    = w_lim & DUTY_MASK;
        // Truncation toward zero: only a whole unit of reverse sets the bit.
        w_rev     = r_cmd[47] && (w_lim != 8'd0);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= KP_RESET;
            r_ki   <= KI_RESET;
            r_kd   <= KD_RESET;
            r_base <= BASE_RESET;
            r_max  <= MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KP:   r_kp   <= i_cfg_data;
                CFG_KI:   r_ki   <= i_cfg_data;
                CFG_KD:   r_kd   <= i_cfg_data;
                CFG_BASE: r_base <= i_cfg_data[7:0];
                CFG_MAX:  r_max  <= i_cfg_data[7:0];
                default:  ;
            endcase
        end
    end

    // Controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_int  <= '0;
        end else if (r_state == S_ACC_I) begin
            r_prev <= r_err;
            r_int  <= w_int_clamped;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_err    <= (i_in.sensor_hits == 5'd0) ? r_prev
                                                           : ERR_LUT[i_in.sensor_hits];
                    r_ms     <= (i_in.elapsed_ms == 16'd0) ? 16'd1 : i_in.elapsed_ms;
                    r_l_duty <= 8'd0;
                    r_l_rev  <= 1'b0;
                    r_r_duty <= 8'd0;
                    r_r_rev  <= 1'b0;
                end
            end
            S_MUL_EMS: r_prod <= w_prod;
            S_LOAD_I: begin
                r_quo  <= {w_prod_abs[25:0], 8'h00};
                r_rem  <= '0;
                r_dneg <= r_prod[40];
                r_dvsr <= MS_PER_S;
                r_cnt  <= '0;
                r_prod <= w_prod;
            end
            S_DIV_I, S_DIV_D: begin
                {r_rem, r_quo} <= w_div_next;
                r_cnt          <= r_cnt + 1'b1;
            end
            S_ACC_I: begin
                r_quo  <= w_prod_abs[DIV_BITS-1:0];
                r_rem  <= '0;
                r_dneg <= r_prod[40];
                r_dvsr <= r_ms;
                r_cnt  <= '0;
            end
            S_MUL_P: begin
                r_deriv <= r_dneg ? -w_q21 : w_q21;
                r_prod  <= w_prod;
            end
            S_MUL_I: begin
                r_acc  <= {w_prod48[39:0], 8'h00};
                r_prod <= w_prod;
            end
            S_MUL_D: begin
                r_acc  <= r_acc + w_prod48;
                r_prod <= w_prod;
            end
            S_SUM:   r_acc <= r_acc + {w_prod48[39:0], 8'h00};
            S_CMD_L: r_cmd <= w_base48 + r_acc;
            S_DRV_L: begin
                r_l_duty <= w_duty;
                r_l_rev  <= w_rev;
            end
            S_CMD_R: r_cmd <= w_base48 - r_acc;
            S_DRV_R: begin
                r_r_duty <= w_duty;
                r_r_rev  <= w_rev;
            end
            default: ;
        endcase
    end

    // Output register: loaded once the sequencer hands over a finished beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_PUT && w_slot_free) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && w_slot_free) begin
            r_o_l_duty <= r_l_duty;
            r_o_l_rev  <= r_l_rev;
            r_o_r_duty <= r_r_duty;
            r_o_r_rev  <= r_r_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_in.enabled ? S_MUL_EMS : S_PUT;
                end
            end
            S_MUL_EMS: n_state = S_LOAD_I;
            S_LOAD_I:  n_state = S_DIV_I;
            S_DIV_I:   n_state = w_div_last ? S_ACC_I : S_DIV_I;
            S_ACC_I:   n_state = S_DIV_D;
            S_DIV_D:   n_state = w_div_last ? S_MUL_P : S_DIV_D;
            S_MUL_P:   n_state = S_MUL_I;
            S_MUL_I:   n_state = S_MUL_D;
            S_MUL_D:   n_state = S_SUM;
            S_SUM:     n_state = S_CMD_L;
            S_CMD_L:   n_state = S_DRV_L;
            S_DRV_L:   n_state = S_CMD_R;
            S_CMD_R:   n_state = S_DRV_R;
            S_DRV_R:   n_state = S_PUT;
            S_PUT:     n_state = w_slot_free ? S_IDLE : S_PUT;
            default:   n_state = S_IDLE;
        endcase
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_o_valid;
    assign o_out.left_duty     = r_o_l_duty;
    assign o_out.left_reverse  = r_o_l_rev;
    assign o_out.right_duty    = r_o_r_duty;
    assign o_out.right_reverse = r_o_r_rev;

endmodule

@@ design/lfpd_checker.sv @@
// ----------------------------------------------------------------------------
// lfpd_checker: port-level checks for the line-follow PID drive
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module lfpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_left_duty,
    input logic       i_left_reverse,
    input logic [7:0] i_right_duty,
    input logic       i_right_reverse
);

    // No result beat is offered straight after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // The block works on one step at a time: an accepted beat drops ready.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready after a beat was accepted");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat withdrawn before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_left_duty) && $stable(i_left_reverse) &&
             $stable(i_right_duty) && $stable(i_right_reverse)))
        else $error("stalled result beat changed");

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_left_duty     (o_out.left_duty),
    .i_left_reverse  (o_out.left_reverse),
    .i_right_duty    (o_out.right_duty),
    .i_right_reverse (o_out.right_reverse)
);

@@ tb/tb_line_follow_pid_drive.sv @@
// ----------------------------------------------------------------------------
// tb_line_follow_pid_drive: self-checking bench for the line-follow PID drive
// A directed table of control steps and register writes is run first, then
// random phases with fresh gains and speeds under different idling patterns.
// Every result beat is compared with a fixed-point model of the PID law, or with the written value of a typed row.
// ----------------------------------------------------------------------------
module tb_line_follow_pid_drive;
    import lfpd_pkg::*;

    localparam longint Q24           = 64'sd16777216;
    localparam longint INTEGRAL_CAP  = 64'sd3276800;
    localparam int     SETTLE_CYCLES = 60;
    localparam int     PHASES        = 8;
    localparam int     PHASE_BEATS   = 75;

    typedef struct packed {
        logic [7:0] left_duty;
        logic       left_reverse;
        logic [7:0] right_duty;
        logic       right_reverse;
    } t_motor_cmd;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [15:0]          cfg_data;
        logic                 en;
        logic [4:0]           hits;
        logic [15:0]          ms;
        logic                 typed;
        t_motor_cmd           want;
    } t_step_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lfpd_in_if  in_ch();
    lfpd_out_if out_ch();

    line_follow_pid_drive uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Register copies and controller state of the model.
    logic [15:0]         cfg_kp;
    logic [15:0]         cfg_ki;
    logic [15:0]         cfg_kd;
    logic [7:0]          cfg_base;
    logic [7:0]          cfg_max;
    logic signed [10:0]  prev_err;
    logic signed [22:0]  err_int;

    t_motor_cmd pending_cmds[$];
    t_step_row  dir_rows[$];
    int         mismatch_count;
    int         send_pct;
    int         recv_pct;

    always #5 i_clk = ~i_clk;

    function automatic void split_motor(input longint cmd, output logic [7:0] duty,
                                        output logic rev);
        longint lim;
        longint c;
        longint whole;
        lim = longint'(cfg_max) * Q24;
        c = cmd;
        if (c > lim) c = lim;
        if (c < -lim) c = -lim;
        whole = c / Q24;
        rev = (whole < 0);
        duty = 8'(rev ? -whole : whole) & DUTY_MASK;
    endfunction

    function automatic t_motor_cmd predict_drive(input logic en, input logic [4:0] hits,
                                                 input logic [15:0] ms_in);
        t_motor_cmd r;
        int         pos_sum;
        int         hit_cnt;
        int         err;
        longint     ms;
        longint     acc;
        longint     deriv;
        longint     corr;
        longint     base;
        r = '0;
        if (!en) return r;
        pos_sum = 0;
        hit_cnt = 0;
        for (int i = 0; i < 5; i++) begin
            if (hits[i]) begin
                pos_sum += i - 2;
                hit_cnt++;
            end
        end
        // With no line in view the controller keeps steering on the last error.
        err = (hit_cnt == 0) ? int'(prev_err) : (pos_sum * 256) / hit_cnt;
        ms = (ms_in == 16'd0) ? 64'sd1 : longint'(ms_in);
        acc = longint'(err_int) + (longint'(err) * ms * 256) / 1000;
        if (acc > INTEGRAL_CAP) acc = INTEGRAL_CAP;
        if (acc < -INTEGRAL_CAP) acc = -INTEGRAL_CAP;
        err_int = 23'(acc);
        deriv = (longint'(err - int'(prev_err)) * 1000) / ms;
        prev_err = 11'(err);
        corr = longint'(cfg_kp) * err * 256 + longint'(cfg_ki) * acc
             + longint'(cfg_kd) * deriv * 256;
        base = longint'(cfg_base) * Q24;
        split_motor(base + corr, r.left_duty, r.left_reverse);
        split_motor(base - corr, r.right_duty, r.right_reverse);
        return r;
    endfunction

    function automatic t_step_row beat_row(input logic en, input logic [4:0] hits,
                                           input logic [15:0] ms);
        t_step_row r;
        r = '0;
        r.en = en;
        r.hits = hits;
        r.ms = ms;
        return r;
    endfunction

    function automatic t_step_row typed_row(input logic en, input logic [4:0] hits,
                                            input logic [15:0] ms, input t_motor_cmd want);
        t_step_row r;
        r = beat_row(en, hits, ms);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic t_step_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [15:0] data);
        t_step_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5)) inside
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 1023));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_KP:   cfg_kp = data;
            CFG_KI:   cfg_ki = data;
            CFG_KD:   cfg_kd = data;
            CFG_BASE: cfg_base = data[7:0];
            CFG_MAX:  cfg_max = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stops sending and lets the block run dry before registers are touched.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_beat(input t_step_row r);
        t_motor_cmd predicted;
        @(negedge i_clk);
        while (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.enabled     <= r.en;
        in_ch.sensor_hits <= r.hits;
        in_ch.elapsed_ms  <= r.ms;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = predict_drive(r.en, r.hits, r.ms);
        pending_cmds.push_back(r.typed ? r.want : predicted);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge i_clk) begin
        out_ch.ready <= (recv_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= recv_pct);
    end

    always @(posedge i_clk) begin
        t_motor_cmd want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result beat, got %0d/%0d %0d/%0d", $time,
                         out_ch.left_duty, out_ch.left_reverse,
                         out_ch.right_duty, out_ch.right_reverse);
                mismatch_count++;
            end else begin
                want = pending_cmds.pop_front();
                check_field("left_duty", want.left_duty, out_ch.left_duty);
                check_field("left_reverse", want.left_reverse, out_ch.left_reverse);
                check_field("right_duty", want.right_duty, out_ch.right_duty);
                check_field("right_reverse", want.right_reverse, out_ch.right_reverse);
            end
        end
    end

    initial begin
        #3000000;
        $display("FAIL line_follow_pid_drive");
        $finish;
    end

    initial begin
        t_step_row   r;
        logic [4:0]  hits;
        logic [15:0] ms;
        int          p;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.enabled = 1'b0;
        in_ch.sensor_hits = '0;
        in_ch.elapsed_ms = '0;
        send_pct = 0;
        recv_pct = 0;
        mismatch_count = 0;
        cfg_kp = KP_RESET;
        cfg_ki = KI_RESET;
        cfg_kd = KD_RESET;
        cfg_base = BASE_RESET;
        cfg_max = MAX_RESET;
        prev_err = '0;
        err_int = '0;

        // Straight ahead from reset drives both motors at base speed.
        dir_rows.push_back(typed_row(1'b1, 5'b00100, 16'd10, {8'd70, 1'b0, 8'd70, 1'b0}));
        dir_rows.push_back(typed_row(1'b0, 5'b11111, 16'hFFFF, '0));
        // No line and zero time, with zero error still held.
        dir_rows.push_back(typed_row(1'b1, 5'b00000, 16'd0, {8'd70, 1'b0, 8'd70, 1'b0}));
        dir_rows.push_back(beat_row(1'b1, 5'b00001, 16'd0));
        dir_rows.push_back(beat_row(1'b1, 5'b10000, 16'hFFFF));
        dir_rows.push_back(beat_row(1'b1, 5'b11111, 16'd1));
        dir_rows.push_back(beat_row(1'b1, 5'b00000, 16'd100));
        dir_rows.push_back(typed_row(1'b0, 5'b00000, 16'd0, '0));
        dir_rows.push_back(beat_row(1'b1, 5'b01010, 16'd1000));
        dir_rows.push_back(beat_row(1'b1, 5'b00011, 16'd7));
        dir_rows.push_back(beat_row(1'b1, 5'b11000, 16'd250));
        dir_rows.push_back(beat_row(1'b1, 5'b00110, 16'd3));
        dir_rows.push_back(beat_row(1'b1, 5'b01100, 16'd40));
        // A zero speed limit stops both motors whatever the error.
        dir_rows.push_back(cfg_row(CFG_MAX, 16'd0));
        dir_rows.push_back(typed_row(1'b1, 5'b00001, 16'd500, '0));
        dir_rows.push_back(typed_row(1'b1, 5'b10000, 16'd0, '0));
        // Zero gains leave only the base speed.
        dir_rows.push_back(cfg_row(CFG_MAX, 16'd255));
        dir_rows.push_back(cfg_row(CFG_KP, 16'd0));
        dir_rows.push_back(cfg_row(CFG_KI, 16'd0));
        dir_rows.push_back(cfg_row(CFG_KD, 16'd0));
        dir_rows.push_back(cfg_row(CFG_BASE, 16'd255));
        dir_rows.push_back(typed_row(1'b1, 5'b00100, 16'd20, {8'd255, 1'b0, 8'd255, 1'b0}));
        dir_rows.push_back(typed_row(1'b1, 5'b00001, 16'hFFFF,
                                     {8'd255, 1'b0, 8'd255, 1'b0}));
        dir_rows.push_back(cfg_row(CFG_KP, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_KI, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_KD, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_BASE, 16'd0));
        dir_rows.push_back(cfg_row(CFG_MAX, 16'd1));
        dir_rows.push_back(beat_row(1'b1, 5'b10000, 16'd1));
        dir_rows.push_back(beat_row(1'b1, 5'b00001, 16'd1));
        // A long step with no line drives the integral into its clamp.
        dir_rows.push_back(beat_row(1'b1, 5'b00000, 16'hFFFF));
        dir_rows.push_back(beat_row(1'b1, 5'b10001, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_KP, KP_RESET));
        dir_rows.push_back(cfg_row(CFG_KI, KI_RESET));
        dir_rows.push_back(cfg_row(CFG_KD, KD_RESET));
        dir_rows.push_back(cfg_row(CFG_BASE, 16'(BASE_RESET)));
        dir_rows.push_back(cfg_row(CFG_MAX, 16'(MAX_RESET)));
        dir_rows.push_back(beat_row(1'b1, 5'b11111, 16'hFFFF));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            if (r.is_cfg) begin
                settle();
                write_reg(r.cfg_idx, r.cfg_data);
            end else begin
                send_beat(r);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_reg(CFG_KP, pick_gain());
            write_reg(CFG_KI, pick_gain());
            write_reg(CFG_KD, pick_gain());
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_BASE, 16'd0);
                1:       write_reg(CFG_BASE, 16'd255);
                default: write_reg(CFG_BASE, 16'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_MAX, 16'd0);
                1:       write_reg(CFG_MAX, 16'd1);
                2:       write_reg(CFG_MAX, 16'd255);
                default: write_reg(CFG_MAX, 16'($urandom_range(1, 255)));
            endcase
            case (ph % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 67; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 67; end
                default: begin send_pct = 22; recv_pct = 22; end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(0, 99) < 70) begin
                    // A line under one sensor or straddling two, with an elapsed time of 1 to 50 ms.
                    p = $urandom_range(0, 4);
                    hits = ($urandom_range(0, 1) && p < 4) ? (5'b00011 << p) : (5'b00001 << p);
                    r = beat_row(1'b1, hits, 16'($urandom_range(1, 50)));
                end else begin
                    case ($urandom_range(0, 3))
                        0:       ms = 16'd0;
                        1:       ms = 16'hFFFF;
                        default: ms = 16'($urandom_range(0, 65535));
                    endcase
                    r = beat_row($urandom_range(0, 99) < 80, 5'($urandom_range(0, 31)), ms);
                end
                send_beat(r);
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("PASS line_follow_pid_drive");
        end else begin
            $display("FAIL line_follow_pid_drive");
        end
        $finish;
    end

endmodule
